// ===== design/cau_pkg.sv =====
// shared types, widths, opcodes and saturation helper for the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;
  localparam int NW = PW + FB;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 overflow;
    logic                 div_by_zero;
  } out_t;

  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [PW-1:0] rem_re;
    logic [PW-1:0] rem_im;
    logic [DW-1:0] num_re;
    logic [DW-1:0] num_im;
    logic [DW-1:0] q_re;
    logic [DW-1:0] q_im;
    logic [PW-1:0] den;
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic          ovf;
  } div_t;

  // returns {overflow, saturated value}
  function automatic logic [DW:0] sat_fn(input logic signed [SW-1:0] v);
    logic [SW-DW:0] hi;
    logic [DW:0]    r;
    hi = v[SW-1:DW-1];
    if ((hi == '0) || (hi == '1)) begin
      r = {1'b0, v[DW-1:0]};
    end else if (v[SW-1]) begin
      r = {1'b1, MINV};
    end else begin
      r = {1'b1, MAXV};
    end
    return r;
  endfunction

endpackage

// ===== design/cau_front.sv =====
// front end: products, sums, scaling and divide setup over three stages
// depends on cau_pkg
module cau_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  cau_pkg::in_t  in_data,
  output logic          out_vld,
  output cau_pkg::div_t out_data
);

  // stage 1
  logic                          s1_vld_r;
  logic [1:0]                    s1_op_r;
  logic signed [cau_pkg::PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [cau_pkg::PW-1:0]        d_rr_r, d_ii_r;
  logic signed [cau_pkg::DW:0]   as_re_r, as_im_r;
  logic signed [cau_pkg::DW:0]   as_re_nxt, as_im_nxt;

  always_comb begin
    if (in_data.req_type == cau_pkg::OP_SUB) begin
      as_re_nxt = {in_data.a_re[cau_pkg::DW-1], in_data.a_re}
                - {in_data.b_re[cau_pkg::DW-1], in_data.b_re};
      as_im_nxt = {in_data.a_im[cau_pkg::DW-1], in_data.a_im}
                - {in_data.b_im[cau_pkg::DW-1], in_data.b_im};
    end else begin
      as_re_nxt = {in_data.a_re[cau_pkg::DW-1], in_data.a_re}
                + {in_data.b_re[cau_pkg::DW-1], in_data.b_re};
      as_im_nxt = {in_data.a_im[cau_pkg::DW-1], in_data.a_im}
                + {in_data.b_im[cau_pkg::DW-1], in_data.b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= in_data.req_type;
      p_rr_r  <= cau_pkg::PW'(in_data.a_re * in_data.b_re);
      p_ii_r  <= cau_pkg::PW'(in_data.a_im * in_data.b_im);
      p_ri_r  <= cau_pkg::PW'(in_data.a_re * in_data.b_im);
      p_ir_r  <= cau_pkg::PW'(in_data.a_im * in_data.b_re);
      d_rr_r  <= cau_pkg::PW'(in_data.b_re * in_data.b_re);
      d_ii_r  <= cau_pkg::PW'(in_data.b_im * in_data.b_im);
      as_re_r <= as_re_nxt;
      as_im_r <= as_im_nxt;
    end
  end

  // stage 2
  logic                          s2_vld_r;
  logic [1:0]                    s2_op_r;
  logic signed [cau_pkg::SW-1:0] n_re_r, n_im_r, n_re_nxt, n_im_nxt;
  logic [cau_pkg::PW-1:0]        den_r;
  logic signed [cau_pkg::DW:0]   as2_re_r, as2_im_r;
  logic signed [cau_pkg::SW-1:0] e_rr, e_ii, e_ri, e_ir;

  always_comb begin
    e_rr = {p_rr_r[cau_pkg::PW-1], p_rr_r};
    e_ii = {p_ii_r[cau_pkg::PW-1], p_ii_r};
    e_ri = {p_ri_r[cau_pkg::PW-1], p_ri_r};
    e_ir = {p_ir_r[cau_pkg::PW-1], p_ir_r};
    if (s1_op_r == cau_pkg::OP_DIV) begin
      n_re_nxt = e_rr + e_ii;
      n_im_nxt = e_ir - e_ri;
    end else begin
      n_re_nxt = e_rr - e_ii;
      n_im_nxt = e_ri + e_ir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r  <= s1_op_r;
      n_re_r   <= n_re_nxt;
      n_im_r   <= n_im_nxt;
      den_r    <= d_rr_r + d_ii_r;
      as2_re_r <= as_re_r;
      as2_im_r <= as_im_r;
    end
  end

  // stage 3
  cau_pkg::div_t                 s3_nxt;
  logic                          s3_vld_r;
  cau_pkg::div_t                 s3_r;
  logic signed [cau_pkg::SW-1:0] bias, sc_re, sc_im, x_re, x_im;
  logic [cau_pkg::DW:0]          st_re, st_im;
  logic [cau_pkg::PW-1:0]        mag_re, mag_im;
  logic [cau_pkg::NW-1:0]        big_re, big_im, top_re, top_im, den_x;
  logic signed [cau_pkg::SW-1:0] neg_re_v, neg_im_v;

  always_comb begin
    bias = cau_pkg::SW'((1 << cau_pkg::FB) - 1);
    sc_re = $signed(n_re_r + (n_re_r[cau_pkg::SW-1] ? bias : '0)) >>> cau_pkg::FB;
    sc_im = $signed(n_im_r + (n_im_r[cau_pkg::SW-1] ? bias : '0)) >>> cau_pkg::FB;
    if (s2_op_r == cau_pkg::OP_MUL) begin
      x_re = sc_re;
      x_im = sc_im;
    end else begin
      x_re = {{(cau_pkg::SW-cau_pkg::DW-1){as2_re_r[cau_pkg::DW]}}, as2_re_r};
      x_im = {{(cau_pkg::SW-cau_pkg::DW-1){as2_im_r[cau_pkg::DW]}}, as2_im_r};
    end
    st_re = cau_pkg::sat_fn(x_re);
    st_im = cau_pkg::sat_fn(x_im);

    neg_re_v = -n_re_r;
    neg_im_v = -n_im_r;
    mag_re = n_re_r[cau_pkg::SW-1] ? neg_re_v[cau_pkg::PW-1:0] : n_re_r[cau_pkg::PW-1:0];
    mag_im = n_im_r[cau_pkg::SW-1] ? neg_im_v[cau_pkg::PW-1:0] : n_im_r[cau_pkg::PW-1:0];
    big_re = {mag_re, {cau_pkg::FB{1'b0}}};
    big_im = {mag_im, {cau_pkg::FB{1'b0}}};
    top_re = big_re >> cau_pkg::DW;
    top_im = big_im >> cau_pkg::DW;
    den_x  = {{cau_pkg::FB{1'b0}}, den_r};

    s3_nxt.is_div = (s2_op_r == cau_pkg::OP_DIV);
    s3_nxt.dz     = (s2_op_r == cau_pkg::OP_DIV) && (den_r == '0);
    s3_nxt.neg_re = n_re_r[cau_pkg::SW-1];
    s3_nxt.neg_im = n_im_r[cau_pkg::SW-1];
    s3_nxt.ovf_re = (top_re >= den_x);
    s3_nxt.ovf_im = (top_im >= den_x);
    s3_nxt.rem_re = top_re[cau_pkg::PW-1:0];
    s3_nxt.rem_im = top_im[cau_pkg::PW-1:0];
    s3_nxt.num_re = big_re[cau_pkg::DW-1:0];
    s3_nxt.num_im = big_im[cau_pkg::DW-1:0];
    s3_nxt.q_re   = '0;
    s3_nxt.q_im   = '0;
    s3_nxt.den    = den_r;
    s3_nxt.res_re = st_re[cau_pkg::DW-1:0];
    s3_nxt.res_im = st_im[cau_pkg::DW-1:0];
    s3_nxt.ovf    = st_re[cau_pkg::DW] | st_im[cau_pkg::DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_data = s3_r;

endmodule

// ===== design/cau_div_step.sv =====
// one quotient bit of the pipelined long division, both result parts
// depends on cau_pkg
module cau_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  cau_pkg::div_t in_data,
  output logic          out_vld,
  output cau_pkg::div_t out_data
);

  logic                   vld_r;
  cau_pkg::div_t          pay_r, pay_nxt;
  logic [cau_pkg::PW:0]   r_re, r_im, d_x;
  logic                   b_re, b_im;

  always_comb begin
    d_x  = {1'b0, in_data.den};
    r_re = {in_data.rem_re, in_data.num_re[cau_pkg::DW-1]};
    r_im = {in_data.rem_im, in_data.num_im[cau_pkg::DW-1]};
    b_re = (r_re >= d_x);
    b_im = (r_im >= d_x);
    pay_nxt        = in_data;
    pay_nxt.rem_re = b_re ? cau_pkg::PW'(r_re - d_x) : r_re[cau_pkg::PW-1:0];
    pay_nxt.rem_im = b_im ? cau_pkg::PW'(r_im - d_x) : r_im[cau_pkg::PW-1:0];
    pay_nxt.num_re = {in_data.num_re[cau_pkg::DW-2:0], 1'b0};
    pay_nxt.num_im = {in_data.num_im[cau_pkg::DW-2:0], 1'b0};
    pay_nxt.q_re   = {in_data.q_re[cau_pkg::DW-2:0], b_re};
    pay_nxt.q_im   = {in_data.q_im[cau_pkg::DW-2:0], b_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_r <= pay_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = pay_r;

endmodule

// ===== design/complex_arithmetic_unit_core.sv =====
// Complex add, subtract, multiply and divide on signed Q16.16 operands, with saturation.
// One transaction is accepted every cycle while the output is not stalled; each result passes
// through three front stages, one long-division stage per quotient bit, 32 of them, and
// the output register; the long-division pipeline sets the depth. All stages
// advance together and hold while the output is stalled. depends on cau_pkg, cau_front,
// cau_div_step
module complex_arithmetic_unit_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);

  logic                adv;
  logic                out_valid_r;
  cau_pkg::out_t       out_data_r, out_nxt;
  logic                vld_c [0:cau_pkg::DW];
  cau_pkg::div_t       pay_c [0:cau_pkg::DW];
  cau_pkg::div_t       f;
  logic [cau_pkg::DW-1:0] qn_re, qn_im, v_re, v_im;
  logic                o_re, o_im;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_data  (in_data),
    .out_vld  (vld_c[0]),
    .out_data (pay_c[0])
  );

  for (genvar i = 0; i < cau_pkg::DW; i++) begin : g_div
    cau_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld_c[i]),
      .in_data  (pay_c[i]),
      .out_vld  (vld_c[i+1]),
      .out_data (pay_c[i+1])
    );
  end

  always_comb begin
    f     = pay_c[cau_pkg::DW];
    qn_re = -f.q_re;
    qn_im = -f.q_im;
    if (f.neg_re) begin
      o_re = f.ovf_re || (f.q_re > cau_pkg::MINV);
      v_re = o_re ? cau_pkg::MINV : qn_re;
    end else begin
      o_re = f.ovf_re || f.q_re[cau_pkg::DW-1];
      v_re = o_re ? cau_pkg::MAXV : f.q_re;
    end
    if (f.neg_im) begin
      o_im = f.ovf_im || (f.q_im > cau_pkg::MINV);
      v_im = o_im ? cau_pkg::MINV : qn_im;
    end else begin
      o_im = f.ovf_im || f.q_im[cau_pkg::DW-1];
      v_im = o_im ? cau_pkg::MAXV : f.q_im;
    end
    if (!f.is_div) begin
      out_nxt.res_re      = f.res_re;
      out_nxt.res_im      = f.res_im;
      out_nxt.overflow    = f.ovf;
      out_nxt.div_by_zero = 1'b0;
    end else if (f.dz) begin
      out_nxt.res_re      = '0;
      out_nxt.res_im      = '0;
      out_nxt.overflow    = 1'b0;
      out_nxt.div_by_zero = 1'b1;
    end else begin
      out_nxt.res_re      = v_re;
      out_nxt.res_im      = v_im;
      out_nxt.overflow    = o_re | o_im;
      out_nxt.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_c[cau_pkg::DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.div_by_zero |->
      out_data_r.res_re == '0 && out_data_r.res_im == '0 && !out_data_r.overflow)
    else $error("divide by zero result not cleared");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.overflow |->
      out_data_r.res_re == cau_pkg::MAXV || out_data_r.res_re == cau_pkg::MINV ||
      out_data_r.res_im == cau_pkg::MAXV || out_data_r.res_im == cau_pkg::MINV)
    else $error("overflow flagged without a saturated part");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_c[cau_pkg::DW] |=> out_valid_r)
    else $error("transaction lost at output register");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for complex_arithmetic_unit_core: exact complex add/sub/mul/div predictor,
// randomized valid/stall traffic and an in-order result scoreboard
// depends on cau_pkg and the complex_arithmetic_unit_core rtl
`timescale 1ns / 100ps

module testbench;

  localparam int NRAND = 1350;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  cau_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  cau_pkg::out_t out_data;

  int    err_count = 0;
  bit    no_idle = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // saturate an exact signed value to the data width
  function automatic logic [cau_pkg::DW:0] clamp(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) return {1'b1, cau_pkg::MAXV};
    if (v < lo) return {1'b1, cau_pkg::MINV};
    return {1'b0, v[cau_pkg::DW-1:0]};
  endfunction

  // truncating signed divide toward zero
  function automatic logic signed [127:0] tdiv(input logic signed [127:0] n,
                                               input logic signed [127:0] d);
    logic signed [127:0] an;
    logic signed [127:0] q;
    an = (n < 0) ? -n : n;
    q = an / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cau_pkg::out_t complex_result(input cau_pkg::in_t t);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic [cau_pkg::DW:0] sr, si;
    cau_pkg::out_t r;
    ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
    r = '0;
    case (t.req_type)
      cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::OP_MUL: begin
        re = tdiv(ar * br - ai * bi, 128'sd65536);
        im = tdiv(ar * bi + ai * br, 128'sd65536);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
          return r;
        end
        re = tdiv((ar * br + ai * bi) * 128'sd65536, den);
        im = tdiv((ai * br - ar * bi) * 128'sd65536, den);
      end
    endcase
    sr = clamp(re);
    si = clamp(im);
    r.res_re = sr[cau_pkg::DW-1:0];
    r.res_im = si[cau_pkg::DW-1:0];
    r.overflow = sr[cau_pkg::DW] | si[cau_pkg::DW];
    return r;
  endfunction

  class result_board;
    cau_pkg::out_t pending[$];
    int   n_in;
    int   n_out;
    int   n_ovf;
    int   n_dz;

    function void note_input(input cau_pkg::in_t t);
      pending.push_back(complex_result(t));
      n_in++;
    endfunction

    task check_result(input cau_pkg::out_t got);
      cau_pkg::out_t want;
      n_out++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.res_re, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.res_re !== want.res_re) report_mismatch("res_re", got.res_re, want.res_re);
      if (got.res_im !== want.res_im) report_mismatch("res_im", got.res_im, want.res_im);
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
      if (got.div_by_zero !== want.div_by_zero)
        report_mismatch("div_by_zero", 32'(got.div_by_zero), 32'(want.div_by_zero));
      n_ovf += int'(want.overflow);
      n_dz += int'(want.div_by_zero);
    endtask
  endclass

  result_board board;

  complex_arithmetic_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 28);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_data);
      out_stall <= idle_now();
    end
  end

  // hold valid with the item until accepted, optionally idling first
  task automatic send(input cau_pkg::in_t t);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(t);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(5))
      0: return $urandom;
      1: return {{16{1'b0}}, 16'($urandom)};
      2: return {{14{1'($urandom_range(1))}}, 18'($urandom)};
      3: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      4: return $urandom_range(1) ? cau_pkg::MAXV : cau_pkg::MINV;
      default: return 32'($signed(8'($urandom))) << $urandom_range(16);
    endcase
  endfunction

  task automatic send_op(input logic [1:0] op, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    cau_pkg::in_t t;
    t.req_type = op; t.a_re = ar; t.a_im = ai; t.b_re = br; t.b_im = bi;
    send(t);
  endtask

  initial begin
    cau_pkg::in_t t;
    int  k;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each op, extremes, saturation, zero divisor, truncation
    send_op(cau_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_op(cau_pkg::OP_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_op(cau_pkg::OP_MUL, 32'h0001_8000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_op(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_op(cau_pkg::OP_ADD, cau_pkg::MAXV, cau_pkg::MINV, cau_pkg::MAXV, cau_pkg::MINV);
    send_op(cau_pkg::OP_SUB, cau_pkg::MAXV, cau_pkg::MINV, cau_pkg::MINV, cau_pkg::MAXV);
    send_op(cau_pkg::OP_SUB, cau_pkg::MINV, cau_pkg::MAXV, cau_pkg::MAXV, cau_pkg::MINV);
    send_op(cau_pkg::OP_MUL, cau_pkg::MAXV, cau_pkg::MAXV, cau_pkg::MAXV, cau_pkg::MINV);
    send_op(cau_pkg::OP_MUL, cau_pkg::MINV, cau_pkg::MINV, cau_pkg::MINV, cau_pkg::MINV);
    send_op(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
    send_op(cau_pkg::OP_MUL, 32'h0000_0001, 32'h0, 32'h0000_0001, 32'h0);
    send_op(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_op(cau_pkg::OP_DIV, cau_pkg::MAXV, cau_pkg::MINV, 32'h0, 32'h0);
    send_op(cau_pkg::OP_DIV, cau_pkg::MAXV, cau_pkg::MAXV, 32'h0000_0001, 32'h0);
    send_op(cau_pkg::OP_DIV, cau_pkg::MINV, cau_pkg::MINV, 32'h0, 32'hFFFF_FFFF);
    send_op(cau_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0);
    send_op(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, cau_pkg::MINV, cau_pkg::MINV);
    send_op(cau_pkg::OP_DIV, cau_pkg::MAXV, cau_pkg::MINV, cau_pkg::MAXV, cau_pkg::MAXV);
    send_op(cau_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(cau_pkg::OP_SUB, 32'h0, 32'h0, 32'h0, 32'h0);

    // hold off until the pipeline has drained
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    for (k = 0; k < NRAND; k++) begin
      no_idle = (k >= 500 && k < 700);
      t.req_type = 2'($urandom);
      t.a_re = rand_part();
      t.a_im = rand_part();
      t.b_re = rand_part();
      t.b_im = rand_part();
      if (t.req_type == cau_pkg::OP_DIV && $urandom_range(19) == 0) begin
        t.b_re = '0;
        t.b_im = '0;
      end
      send(t);
    end
    no_idle = 0;
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d transactions, %0d results, %0d saturated, %0d zero divisors",
             board.n_in, board.n_out, board.n_ovf, board.n_dz);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
